// ----- sv/depth_to_normal_map_unit_assert.svh -----
// Assertion macros shared by the depth-to-normal RTL.
`ifndef DEPTH_TO_NORMAL_MAP_UNIT_ASSERT_SVH
`define DEPTH_TO_NORMAL_MAP_UNIT_ASSERT_SVH

// Clocked check, masked while reset is asserted
`define DTN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dtn assertion failed");

// Clocked check that also holds during reset
`define DTN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("dtn assertion failed");

`endif

// ----- sv/dtn_pkg.sv -----
// Package: types, codes and defaults of the depth-to-normal unit.
package dtn_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int FRAC_BITS_DEF = 14;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  // pixel kinds
  localparam logic [1:0] KIND_BORDER  = 2'd0;
  localparam logic [1:0] KIND_INVALID = 2'd1;
  localparam logic [1:0] KIND_VALID   = 2'd2;

  typedef struct packed {
    logic [15:0] depth_sample;
    logic        frame_start;
  } pix_in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [1:0]         pixel_kind;
  } pix_out_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [16:0] dx;
    logic signed [16:0] ndy;
  } grad_t;

endpackage

// ----- sv/depth_to_normal_map_unit.sv -----
// Depth-to-normal unit: turns raster depth pixels into Q1.14 unit surface normals, one result
// per pixel in input order. A front end tracks row and column, reads the previous row from a
// line buffer (one read and one write per pixel) and classifies the pixel; it is registered
// and enters the queue unless it is full. Border and zero-depth pixels go to the result
// register when it is free. A valid interior pixel gets its squares on the pop, a setup step,
// then a bit-serial square-root division that finds one quotient bit per cycle for all three
// components at once. Rate is one pixel per cycle on border/invalid pixels while the output
// does not stall; a valid pixel holds the back end until its result is loaded. A four-entry
// queue absorbs bursts. The line buffer is not cleared; the first row of a frame is border
// and fills it. Register writes take effect at once and belong while the unit is idle.
module depth_to_normal_map_unit import dtn_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pix_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pix_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [11:0] image_width_q;
  logic [15:0] image_height_q;
  logic        push, full, pop, empty;
  grad_t       push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMAGE_WIDTH_RST;
      image_height_q <= IMAGE_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[11:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dtn_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .push_o         (push),
    .push_data_o    (push_data),
    .full_i         (full)
  );

  dtn_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  dtn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sv/dtn_front.sv -----
// Front end: row/column counters, line buffer and gradient classification.
module dtn_front import dtn_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pix_in_t     in_data_i,
  input  logic [11:0] image_width_i,
  input  logic [15:0] image_height_i,
  output logic        push_o,
  output grad_t       push_data_o,
  input  logic        full_i
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CW-1:0] col_q, col_d, col_cur, last_col;
  logic [15:0]   row_q, row_d, row_cur, last_row;
  logic [15:0]   left_q;
  logic          accept;
  logic          border;

  logic          s1_valid_q, s1_valid_d;
  logic [15:0]   s1_c_q, s1_left_q, s1_above_q;
  logic          s1_border_q;

  logic [15:0]   lb_mem [MAX_WIDTH];

  // clamp the frame size
  always_comb begin
    int w;
    w = int'(image_width_i);
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    last_col = CW'(w - 1);
    if (image_height_i < 16'd3) last_row = 16'd2;
    else last_row = image_height_i - 16'd1;
  end

  assign in_stall_o = s1_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign col_cur    = in_data_i.frame_start ? '0 : col_q;
  assign row_cur    = in_data_i.frame_start ? '0 : row_q;
  assign border     = (row_cur == '0) || (row_cur >= last_row) ||
                      (col_cur == '0) || (col_cur >= last_col);

  // raster position after this pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_cur >= last_col) begin
        col_d = '0;
        row_d = (row_cur >= last_row) ? '0 : row_cur + 16'd1;
      end else begin
        col_d = col_cur + CW'(1);
        row_d = row_cur;
      end
    end
  end

  assign push_o     = s1_valid_q && !full_i;
  assign s1_valid_d = accept ? 1'b1 : (push_o ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (accept) left_q <= in_data_i.depth_sample;
    end
  end

  // line buffer: old value read out, new one written at the same column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_above_q      <= lb_mem[col_cur];
      lb_mem[col_cur] <= in_data_i.depth_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_c_q      <= in_data_i.depth_sample;
      s1_left_q   <= left_q;
      s1_border_q <= border;
    end
  end

  // gradients and kind
  always_comb begin
    push_data_o.dx  = $signed({1'b0, s1_c_q}) - $signed({1'b0, s1_left_q});
    push_data_o.ndy = $signed({1'b0, s1_above_q}) - $signed({1'b0, s1_c_q});
    if (s1_border_q) push_data_o.kind = KIND_BORDER;
    else if (s1_c_q == '0) push_data_o.kind = KIND_INVALID;
    else push_data_o.kind = KIND_VALID;
  end

endmodule

// ----- sv/dtn_queue.sv -----
// Short queue decoupling the front end from the normalizer.
`include "depth_to_normal_map_unit_assert.svh"
module dtn_queue import dtn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  grad_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output grad_t pop_data_o,
  output logic  empty_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  grad_t         slots_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;

  assign full_o     = cnt_q == NW'(QUEUE_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = slots_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (pop_i)  rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + NW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= push_data_i;
  end

  `DTN_ASSERT(a_no_push_full, push_i |-> !full_o)
  `DTN_ASSERT(a_no_pop_empty, pop_i |-> !empty_o)
  `DTN_ASSERT(a_cnt_bound, cnt_q <= NW'(QUEUE_DEPTH))
  `DTN_ASSERT(a_ptr_sync, (empty_o || full_o) |-> (wr_q == rd_q))

endmodule

// ----- sv/dtn_back.sv -----
// Back end: bit-serial unit-vector normalizer and result register.
`include "depth_to_normal_map_unit_assert.svh"
module dtn_back import dtn_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  grad_t    pop_data_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pix_out_t out_data_o
);

  localparam int TW = FRAC_BITS + 2;        // quotient bits
  localparam int SH = 2 * FRAC_BITS + 2;    // scale of the squared numerator
  localparam int W  = 2 * FRAC_BITS + 40;   // partial product width
  localparam logic [15:0] NEG_ONE =
    (FRAC_BITS >= 15) ? 16'h8000 : 16'((~(32'd1 << FRAC_BITS)) + 32'd1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic          out_valid_q;
  pix_out_t      out_q, out_d;
  logic          out_free, out_load;

  logic [31:0]   sq_q   [2];
  logic          neg_q  [3];
  logic [W-1:0]  r_q    [3];
  logic [W-1:0]  p_q    [3];
  logic [W-1:0]  a_q    [3];
  logic [TW-1:0] t_q    [3];
  logic [W-1:0]  b_q;
  logic [TW-1:0] mask_q;

  logic [W-1:0]  cand   [3];
  logic          take   [3];
  logic [15:0]   mag_x, mag_y;
  logic [15:0]   res    [3];

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign mag_x = pop_data_i.dx[16]  ? 16'(-pop_data_i.dx)  : pop_data_i.dx[15:0];
  assign mag_y = pop_data_i.ndy[16] ? 16'(-pop_data_i.ndy) : pop_data_i.ndy[15:0];

  // trial bit per lane: (t + 2^b)^2 * S = P + A + B
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cand[i] = p_q[i] + a_q[i] + b_q;
      take[i] = cand[i] <= r_q[i];
    end
  end

  // round, sign and saturate
  always_comb begin
    logic [TW:0]  rnd;
    logic [32:0]  qx;
    for (int i = 0; i < 3; i++) begin
      rnd = {1'b0, t_q[i]} + (TW+1)'(1);
      qx  = 33'(rnd[TW:1]);
      if (neg_q[i]) res[i] = (qx > 33'd32768) ? 16'h8000 : 16'((~qx) + 33'd1);
      else res[i] = (qx > 33'd32767) ? 16'h7FFF : qx[15:0];
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    out_d    = out_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          if (pop_data_i.kind == KIND_VALID) begin
            pop_o   = 1'b1;
            state_d = ST_INIT;
          end else if (out_free) begin
            pop_o    = 1'b1;
            out_load = 1'b1;
            if (pop_data_i.kind == KIND_INVALID) begin
              out_d.normal_x = NEG_ONE;
              out_d.normal_y = NEG_ONE;
              out_d.normal_z = NEG_ONE;
            end else begin
              out_d.normal_x = '0;
              out_d.normal_y = '0;
              out_d.normal_z = '0;
            end
            out_d.pixel_kind = pop_data_i.kind;
          end
        end
      end
      ST_INIT: state_d = ST_RUN;
      ST_RUN:  if (mask_q[0]) state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d.normal_x   = res[0];
          out_d.normal_y   = res[1];
          out_d.normal_z   = res[2];
          out_d.pixel_kind = KIND_VALID;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  // datapath: squares, setup, then one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sq_q[0]  <= mag_x * mag_x;
        sq_q[1]  <= mag_y * mag_y;
        neg_q[0] <= pop_data_i.dx[16];
        neg_q[1] <= pop_data_i.ndy[16];
        neg_q[2] <= 1'b0;
      end
      ST_INIT: begin
        b_q    <= W'({2'b00, sq_q[0]} + {2'b00, sq_q[1]} + 34'd1) << SH;
        r_q[0] <= W'(sq_q[0]) << SH;
        r_q[1] <= W'(sq_q[1]) << SH;
        r_q[2] <= W'(1) << SH;
        mask_q <= TW'(1) << (TW - 1);
        for (int i = 0; i < 3; i++) begin
          p_q[i] <= '0;
          a_q[i] <= '0;
          t_q[i] <= '0;
        end
      end
      ST_RUN: begin
        b_q    <= b_q >> 2;
        mask_q <= mask_q >> 1;
        for (int i = 0; i < 3; i++) begin
          if (take[i]) begin
            p_q[i] <= cand[i];
            a_q[i] <= (a_q[i] + (b_q << 1)) >> 1;
            t_q[i] <= t_q[i] | mask_q;
          end else begin
            a_q[i] <= a_q[i] >> 1;
          end
        end
      end
      default: ;
    endcase
  end

  `DTN_ASSERT(a_mask_onehot, (state_q == ST_RUN) |-> $onehot(mask_q))
  `DTN_ASSERT(a_pop_idle, pop_o |-> (state_q == ST_IDLE))
  `DTN_ASSERT(a_fin_from_run, (state_q == ST_FIN) |-> ($past(state_q) == ST_RUN ||
    $past(state_q) == ST_FIN))
  `DTN_ASSERT(a_load_free, out_load |-> out_free)
  `DTN_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> (state_q == ST_IDLE || rst_ni))

endmodule

// ----- tb/sv/depth_to_normal_map_unit_tb.sv -----
// Testbench for the depth-to-normal unit: directed and random pixel streams checked by a scoreboard.
module depth_to_normal_map_unit_tb;
  import dtn_pkg::*;

  localparam int          FRAC      = FRAC_BITS_DEF;
  localparam int          SETTLE    = 2 * (FRAC + 5) + 10;
  localparam int          LIMIT     = 2000000;
  localparam logic [1:0]  REG_SPARE = 2'd3;

  // Expected normals per accepted pixel, with its own copy of counters and line buffer
  class normal_scoreboard;
    logic [15:0] line_buf [MAX_WIDTH_DEF];
    logic [15:0] left_px;
    int unsigned col, row;
    int unsigned width_reg, height_reg;
    pix_out_t    pending[$];
    int          errors;

    function new();
      left_px    = '0;
      col        = 0;
      row        = 0;
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      if (idx == REG_IMAGE_WIDTH) width_reg = data[11:0];
      else if (idx == REG_IMAGE_HEIGHT) height_reg = data;
    endfunction

    // rounded |v| * 2^FRAC / sqrt(s), found bit by bit in exact integers
    function logic signed [15:0] unit_part(longint v, longint unsigned s);
      logic [127:0] rhs, cand, s_w;
      logic [127:0] t;
      longint unsigned mag, q;
      mag  = (v < 0) ? -v : v;
      rhs  = 128'(mag) * 128'(mag);
      rhs  = rhs << (2 * FRAC + 2);
      s_w  = 128'(s);
      t    = '0;
      for (int b = FRAC + 1; b >= 0; b--) begin
        cand = t | (128'd1 << b);
        if (cand * cand * s_w <= rhs) t = cand;
      end
      q = 64'((t + 128'd1) >> 1);
      if (v < 0) return (q > 32768) ? -16'sd32768 : -16'(q);
      return (q > 32767) ? 16'sd32767 : 16'(q);
    endfunction

    function void note_input(pix_in_t px);
      int unsigned w, h;
      logic [15:0] above;
      longint dx, dy;
      longint unsigned s;
      pix_out_t r;
      w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : width_reg);
      h = (height_reg < 3) ? 3 : height_reg;
      if (px.frame_start) begin
        col = 0;
        row = 0;
      end
      above = (col < MAX_WIDTH_DEF) ? line_buf[col] : '0;
      r = '0;
      r.pixel_kind = KIND_BORDER;
      if (!(row == 0 || row >= h - 1 || col == 0 || col >= w - 1)) begin
        if (px.depth_sample == 0) begin
          r.normal_x   = -16'sd16384;
          r.normal_y   = -16'sd16384;
          r.normal_z   = -16'sd16384;
          r.pixel_kind = KIND_INVALID;
        end else begin
          dx = longint'(px.depth_sample) - longint'(left_px);
          dy = longint'(px.depth_sample) - longint'(above);
          s  = dx * dx + dy * dy + 1;
          r.normal_x   = unit_part(dx, s);
          r.normal_y   = unit_part(-dy, s);
          r.normal_z   = unit_part(1, s);
          r.pixel_kind = KIND_VALID;
        end
      end
      if (col < MAX_WIDTH_DEF) line_buf[col] = px.depth_sample;
      left_px = px.depth_sample;
      if (col + 1 >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end else begin
        col++;
      end
      pending.push_back(r);
    endfunction

    function void check_result(pix_out_t got);
      pix_out_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected normal %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.normal_x !== exp_r.normal_x) begin
        $error("normal_x expected %0d actual %0d", exp_r.normal_x, got.normal_x);
        errors++;
      end
      if (got.normal_y !== exp_r.normal_y) begin
        $error("normal_y expected %0d actual %0d", exp_r.normal_y, got.normal_y);
        errors++;
      end
      if (got.normal_z !== exp_r.normal_z) begin
        $error("normal_z expected %0d actual %0d", exp_r.normal_z, got.normal_z);
        errors++;
      end
      if (got.pixel_kind !== exp_r.pixel_kind) begin
        $error("pixel_kind expected %0d actual %0d", exp_r.pixel_kind, got.pixel_kind);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  pix_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  pix_out_t    out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  normal_scoreboard sb = new();
  bit          tx_quiet, rx_quiet;
  int          rx_hold;
  int          cycles;
  int          sent;
  logic [15:0] last_depth;

  depth_to_normal_map_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("depth_to_normal_map_unit: mismatch");
      $finish;
    end
  end

  // result side: check each accepted normal, then, unless rx_quiet is set, stall for a random stretch
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_data_o);
      rx_hold = rx_quiet ? 0 : $urandom_range(0, 15);
    end
    out_stall_i <= (rx_hold != 0);
    if (rx_hold > 0) rx_hold--;
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one pixel request; valid stays high when the next one follows at once
  task automatic send_pixel(logic [15:0] depth, logic fs);
    int gap;
    pix_in_t px;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    px.depth_sample = depth;
    px.frame_start  = fs;
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(px);
    sent++;
    last_depth = depth;
  endtask

  // sender waits out every pending normal, then the back end settles
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // 3x3 frame around one interior pixel
  task automatic send_frame3(logic [15:0] above, logic [15:0] left, logic [15:0] centre);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(above, 1'b0);
    send_pixel(16'd1, 1'b0);
    send_pixel(left, 1'b0);
    send_pixel(centre, 1'b0);
    send_pixel(16'd0, 1'b0);
    send_pixel(16'd0, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h5A5A, 1'b0);
  endtask

  function automatic logic [15:0] pick_depth(bit smooth);
    if ($urandom_range(0, 15) == 0) return 16'd0;
    if (smooth) return last_depth + 16'($urandom_range(0, 64)) - 16'd32;
    return 16'($urandom);
  endfunction

  task automatic send_random(int n, bit smooth);
    for (int i = 0; i < n; i++) begin
      send_pixel(pick_depth(smooth), (i == 0) || ($urandom_range(0, 59) == 0));
    end
  endtask

  initial begin
    int w, h, n;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_IMAGE_WIDTH;
    cfg_data_i  <= '0;
    rx_hold  = 0;
    cycles   = 0;
    sent     = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    last_depth = 16'd1000;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: sizes below the minimum clamp to 3x3, spare index is ignored
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    write_reg(REG_SPARE, 16'hFFFF);
    send_frame3(16'd0, 16'd0, 16'hFFFF);
    send_frame3(16'd300, 16'd300, 16'd0);
    send_frame3(16'hFFFF, 16'd0, 16'd1);
    drain();

    // counters left past a shrunken size are border and wrap
    write_reg(REG_IMAGE_WIDTH, 16'd8);
    write_reg(REG_IMAGE_HEIGHT, 16'd8);
    send_random(20, 1'b1);
    drain();
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    for (int i = 0; i < 12; i++) send_pixel(pick_depth(1'b0), 1'b0);
    drain();

    // width field at its top, clamped to the line buffer size
    write_reg(REG_IMAGE_WIDTH, 16'd4095);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    send_random(200, 1'b1);
    drain();
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(REG_IMAGE_WIDTH, 16'd6);
    send_random(30, 1'b0);
    drain();

    // random phases with small images
    while (sent < 1250) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      write_reg(REG_IMAGE_WIDTH, 16'(w));
      write_reg(REG_IMAGE_HEIGHT, 16'(h));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 3) * w * h + $urandom_range(0, w);
      send_random(n, $urandom_range(0, 3) != 0);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("depth_to_normal_map_unit: match");
    end else begin
      $display("depth_to_normal_map_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/dtn_pkg.sv
sv/dtn_front.sv
sv/dtn_queue.sv
sv/dtn_back.sv
sv/depth_to_normal_map_unit.sv
tb/sv/depth_to_normal_map_unit_tb.sv
